### rtl/core/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, register indexes and structs of the touch sample stabilizer.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int WIN_SIZE  = 8;
  localparam int WIN_AW    = $clog2(WIN_SIZE);
  localparam int CHANNELS  = 4;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = SAMPLE_W + WIN_AW;
  localparam int CNT_W     = 9;
  localparam int IGN_W     = 4;
  localparam int RETRY_W   = 8;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 12;
  localparam int TDATA_W   = 16;
  localparam int IN_USER_W = 8;
  localparam int OUT_USER_W = 8;

  localparam logic [CH_W-1:0]  FIRST_PRESSURE_CH = CH_W'(2);
  localparam logic [CNT_W-1:0] WIN_SIZE_CNT      = CNT_W'(WIN_SIZE);

  typedef enum logic [CFG_AW-1:0] {
    CFG_IGNORE_COUNT    = 3'd0,
    CFG_MATCH_TOLERANCE = 3'd1,
    CFG_RETRY_LIMIT     = 3'd2,
    CFG_POSITION_BAND   = 3'd3,
    CFG_PRESSURE_BAND   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [IGN_W-1:0]    ignore_count;
    logic [SAMPLE_W-1:0] match_tolerance;
    logic [RETRY_W-1:0]  retry_limit;
    logic [SAMPLE_W-1:0] position_band;
    logic [SAMPLE_W-1:0] pressure_band;
  } cfg_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } win_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [CNT_W-1:0]    count;
  } win_stat_t;

  typedef struct packed {
    logic                status;
    logic [SAMPLE_W-1:0] value;
    logic                value_valid;
  } result_t;

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/core/touch_sample_stabilizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_stabilizer
// Steadies touch converter readings over a shared eight-entry sample window.
//
// in_*  : one converter reading per item, channel in in_tuser.
// out_* : one result per input item, in order; status and valid in out_tuser.
// cfg_* : register writes, taken with cfg_we high; the user must make them
// only while idle, which the block does not enforce. An accepted item is held
// in the input register and its result in the output register. Throughput:
// one item per cycle unless a held result stalls; the window's running sum
// makes the mean ready at once; the only loop is the registered state update.
// Reset: registers return to their defaults, counters and last good values
// clear, both channels drop valid. The window itself is not cleared.
// Stall: a held result keeps out_tdata/out_tuser stable; one more item waits
// in the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module touch_sample_stabilizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tss_pkg::TDATA_W-1:0]    in_tdata,   // [11:0] sample
  input  logic [tss_pkg::IN_USER_W-1:0]  in_tuser,   // [1:0] channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tss_pkg::TDATA_W-1:0]    out_tdata,  // [11:0] value
  output logic [tss_pkg::OUT_USER_W-1:0] out_tuser,  // [0] status, [1] value_valid
  input  logic                           cfg_we,
  input  logic [tss_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [tss_pkg::CFG_DW-1:0]     cfg_wdata
);

  tss_pkg::cfg_t                cfg_r;
  logic                         in_valid_r;
  logic [tss_pkg::CH_W-1:0]     in_ch_r;
  logic [tss_pkg::SAMPLE_W-1:0] in_sample_r;
  logic                         out_valid_r;
  tss_pkg::result_t             res_r;
  tss_pkg::result_t             res;
  tss_pkg::win_ctrl_t           win_ctrl;
  tss_pkg::win_stat_t           win_stat;
  logic                         advance;
  logic                         fire;
  logic                         take;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignore_count    <= tss_pkg::IGN_W'(1);
      cfg_r.match_tolerance <= tss_pkg::SAMPLE_W'(1);
      cfg_r.retry_limit     <= tss_pkg::RETRY_W'(8);
      cfg_r.position_band   <= tss_pkg::SAMPLE_W'(12);
      cfg_r.pressure_band   <= tss_pkg::SAMPLE_W'(12);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tss_pkg::CFG_IGNORE_COUNT:    cfg_r.ignore_count    <= cfg_wdata[tss_pkg::IGN_W-1:0];
        tss_pkg::CFG_MATCH_TOLERANCE: cfg_r.match_tolerance <= cfg_wdata;
        tss_pkg::CFG_RETRY_LIMIT:     cfg_r.retry_limit     <= cfg_wdata[tss_pkg::RETRY_W-1:0];
        tss_pkg::CFG_POSITION_BAND:   cfg_r.position_band   <= cfg_wdata;
        tss_pkg::CFG_PRESSURE_BAND:   cfg_r.pressure_band   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_ch_r     <= in_tuser[tss_pkg::CH_W-1:0];
      in_sample_r <= in_tdata[tss_pkg::SAMPLE_W-1:0];
    end
  end

  tss_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (win_ctrl),
    .sample (in_sample_r),
    .stat   (win_stat)
  );

  tss_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .channel (in_ch_r),
    .sample  (in_sample_r),
    .cfg     (cfg_r),
    .stat    (win_stat),
    .ctrl    (win_ctrl),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tss_pkg::TDATA_W'(res_r.value);
  assign out_tuser  = tss_pkg::OUT_USER_W'({res_r.value_valid, res_r.status});

endmodule

### rtl/core/tss_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_window
// Shared sample ring with running sum, write index and sample counter.
// ----------------------------------------------------------------------------
module tss_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tss_pkg::win_ctrl_t           ctrl,
  input  logic [tss_pkg::SAMPLE_W-1:0] sample,
  output tss_pkg::win_stat_t           stat
);

  logic [tss_pkg::SAMPLE_W-1:0] window_r [tss_pkg::WIN_SIZE];
  logic [tss_pkg::WIN_AW-1:0]   widx_r, widx_nxt;
  logic [tss_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [tss_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [tss_pkg::SUM_W-1:0]    drop_val;

  // first pass after a clear overwrites entries that are not in the sum
  assign drop_val = (count_r < tss_pkg::WIN_SIZE_CNT) ? '0
                    : tss_pkg::SUM_W'(window_r[widx_r]);

  always_comb begin
    widx_nxt  = widx_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (ctrl.clr) begin
      widx_nxt  = '0;
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (ctrl.wr) begin
      widx_nxt  = widx_r + 1'b1;
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + tss_pkg::SUM_W'(sample) - drop_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      widx_r  <= widx_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      window_r[widx_r] <= sample;
    end
  end

  assign stat.mean  = sum_r[tss_pkg::SUM_W-1:tss_pkg::WIN_AW];
  assign stat.count = count_r;

endmodule

### rtl/core/tss_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_decide
// Match, hold-band and forced decision with the per-channel last good values.
// ----------------------------------------------------------------------------
module tss_decide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [tss_pkg::CH_W-1:0]     channel,
  input  logic [tss_pkg::SAMPLE_W-1:0] sample,
  input  tss_pkg::cfg_t                cfg,
  input  tss_pkg::win_stat_t           stat,
  output tss_pkg::win_ctrl_t           ctrl,
  output tss_pkg::result_t             res
);

  logic [tss_pkg::SAMPLE_W-1:0] last_good_r [tss_pkg::CHANNELS];
  logic [tss_pkg::CHANNELS-1:0] known_r;

  logic [tss_pkg::SAMPLE_W-1:0] band;
  logic [tss_pkg::SAMPLE_W-1:0] lg;
  logic [tss_pkg::RETRY_W-1:0]  rep;
  logic [tss_pkg::CNT_W-1:0]    judge_lim;
  logic [tss_pkg::CNT_W-1:0]    force_lim;
  logic [tss_pkg::CNT_W-1:0]    count_inc;
  logic                         judge;
  logic                         match;
  logic                         force_dec;
  logic                         hold;
  logic                         store;

  assign band      = (channel < tss_pkg::FIRST_PRESSURE_CH) ? cfg.position_band
                                                             : cfg.pressure_band;
  assign lg        = last_good_r[channel];
  assign rep       = (cfg.retry_limit == '0) ? tss_pkg::RETRY_W'(1) : cfg.retry_limit;
  assign judge_lim = tss_pkg::CNT_W'(cfg.ignore_count) + tss_pkg::WIN_SIZE_CNT;
  assign force_lim = judge_lim + tss_pkg::CNT_W'(rep);
  assign count_inc = stat.count + 1'b1;

  assign judge     = stat.count >= judge_lim;
  assign match     = judge &&
                     (tss_pkg::abs_diff(stat.mean, sample) <= cfg.match_tolerance);
  assign force_dec = !match && (count_inc >= force_lim);
  assign hold      = known_r[channel] && (tss_pkg::abs_diff(stat.mean, lg) < band);
  assign store     = fire && match && !hold;

  assign ctrl.wr  = fire && !match;
  assign ctrl.clr = fire && (match || force_dec);

  always_comb begin
    res = '0;
    if (match) begin
      res.status      = 1'b1;
      res.value       = hold ? lg : stat.mean;
      res.value_valid = 1'b1;
    end else if (force_dec) begin
      res.status = 1'b1;
      if (known_r[channel]) begin
        res.value       = hold ? lg : stat.mean;
        res.value_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
      for (int i = 0; i < tss_pkg::CHANNELS; i++) begin
        last_good_r[i] <= '0;
      end
    end else if (store) begin
      known_r[channel]     <= 1'b1;
      last_good_r[channel] <= stat.mean;
    end
  end

endmodule
